// File: sv/tal_pkg.sv
// Shared types and constants for the turn arbiter with leases.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps

package tal_pkg;

  localparam int KIND_W = 4;
  localparam int REQ_W  = 3;
  localparam int TAG_W  = 32;
  localparam int WS_W   = 16;
  localparam int ST_W   = 2;
  localparam int POS_W  = 4;

  localparam int SLOTS_DEF  = 8;
  localparam int QUEUE_DEF  = 8;
  localparam int LEASES_DEF = 8;

  localparam logic [KIND_W-1:0] KIND_ACQ   = 4'd0;
  localparam logic [KIND_W-1:0] KIND_ACQQ  = 4'd1;
  localparam logic [KIND_W-1:0] KIND_REL   = 4'd2;
  localparam logic [KIND_W-1:0] KIND_WDR   = 4'd3;
  localparam logic [KIND_W-1:0] KIND_DET   = 4'd4;
  localparam logic [KIND_W-1:0] KIND_LGET  = 4'd5;
  localparam logic [KIND_W-1:0] KIND_LDROP = 4'd6;
  localparam logic [KIND_W-1:0] KIND_LQRY  = 4'd7;
  localparam logic [KIND_W-1:0] KIND_ATT   = 4'd8;

  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_QUEUED = 2'd1;
  localparam logic [ST_W-1:0] ST_BUSY   = 2'd2;
  localparam logic [ST_W-1:0] ST_ERR    = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DEC,
    S_QSCAN,
    S_QSHIFT,
    S_LSCAN,
    S_DONE
  } eng_state_t;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [TAG_W-1:0] tag;
    logic [POS_W-1:0] pos;
    logic [REQ_W-1:0] slot;
  } res_t;

  typedef struct packed {
    logic [WS_W-1:0]  space;
    logic [REQ_W-1:0] owner;
  } lease_ent_t;

endpackage

// File: sv/turn_arbiter_with_leases.sv
// Turn arbiter with leases: one turn lock with a FIFO wait queue, a slot table and a
// workspace lease table. One transaction is worked at a time and yields one result.
// A request that touches no table goes from decode straight to its result; one that
// walks the wait queue reads up to its n queued entries (up to QUEUE_DEPTH) and one that
// walks the lease table reads up to LEASES entries; both tables sit in memories
// read one entry per cycle. The result is held in an output register, so a new
// transaction is taken while the previous result waits.
`timescale 1ns / 1ps

module turn_arbiter_with_leases
  import tal_pkg::*;
#(
  parameter int SLOTS       = SLOTS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEF,
  parameter int LEASES      = LEASES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [KIND_W-1:0] kind,
  input  logic [REQ_W-1:0]  requester,
  input  logic [TAG_W-1:0]  turn_tag,
  input  logic [WS_W-1:0]   workspace,
  input  logic              keeps_target,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [ST_W-1:0]   status,
  output logic [TAG_W-1:0]  turn_tag_res,
  output logic [POS_W-1:0]  position,
  output logic [REQ_W-1:0]  slot
);

  logic idle, res_valid, load, out_valid_next;
  res_t res;

  tal_engine #(
    .SLOTS       (SLOTS),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .LEASES      (LEASES)
  ) u_engine (
    .clk          (clk),
    .rst          (rst),
    .start        (in_valid && idle),
    .kind         (kind),
    .requester    (requester),
    .turn_tag     (turn_tag),
    .workspace    (workspace),
    .keeps_target (keeps_target),
    .idle         (idle),
    .res_valid    (res_valid),
    .res_take     (load),
    .res          (res)
  );

  assign in_stall       = !idle;
  assign load           = res_valid && (!out_valid || !out_stall);
  assign out_valid_next = load || (out_valid && out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status       <= res.status;
      turn_tag_res <= res.tag;
      position     <= res.pos;
      slot         <= res.slot;
    end
  end

endmodule

// File: sv/tal_ram.sv
// Simple dual-port synchronous memory, one write and one registered read.
// Depends on tal_pkg for the defaults of DEPTH and WIDTH.
`timescale 1ns / 1ps

module tal_ram
  import tal_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEF,
  parameter int WIDTH = REQ_W,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: sv/tal_engine.sv
// Request sequencer: slot flags and turn state in registers, wait queue and
// lease table in tal_ram instances scanned one entry per cycle.
// Depends on tal_pkg and tal_ram.
`timescale 1ns / 1ps

module tal_engine
  import tal_pkg::*;
#(
  parameter int SLOTS       = SLOTS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEF,
  parameter int LEASES      = LEASES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [KIND_W-1:0] kind,
  input  logic [REQ_W-1:0]  requester,
  input  logic [TAG_W-1:0]  turn_tag,
  input  logic [WS_W-1:0]   workspace,
  input  logic              keeps_target,
  output logic              idle,
  output logic              res_valid,
  input  logic              res_take,
  output res_t              res
);

  localparam int SAW = $clog2(SLOTS);
  localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW  = $clog2(QUEUE_DEPTH + 1);
  localparam int LAW = (LEASES > 1) ? $clog2(LEASES) : 1;
  localparam int LEW = WS_W + REQ_W;

  eng_state_t state, state_next;

  logic [KIND_W-1:0] kind_r;
  logic [REQ_W-1:0]  req_r;
  logic [TAG_W-1:0]  tag_r;
  logic [WS_W-1:0]   ws_r;
  logic              keeps_r;

  logic [SLOTS-1:0]  slot_active, slot_active_next;
  logic [SLOTS-1:0]  slot_live, slot_live_next;
  logic [SLOTS-1:0]  slot_keeps, slot_keeps_next;
  logic              turn_busy, turn_busy_next;
  logic [TAG_W-1:0]  current_tag, current_tag_next;
  logic [REQ_W-1:0]  turn_owner, turn_owner_next;
  logic [CW-1:0]     wait_count, wait_count_next;
  logic [LEASES-1:0] lease_valid, lease_valid_next;
  logic [TAG_W-1:0]  tag_counter, tag_counter_next;
  logic [CW-1:0]     qidx, qidx_next;
  logic [LAW-1:0]    lidx, lidx_next;
  res_t              res_next;

  logic              q_we;
  logic [QAW-1:0]    q_waddr, q_raddr;
  logic [REQ_W-1:0]  q_wdata, q_rd;
  logic              l_we;
  logic [LAW-1:0]    l_waddr, l_raddr;
  logic [LEW-1:0]    l_wdata, l_rdata;
  lease_ent_t        l_rd;

  logic [SAW-1:0]    sidx;
  logic              bad, act, sess_open, head, contend, can_q, rel_ok;
  logic              q_hit, q_last, l_v, l_sp_hit, l_own, l_last, l_stop;
  logic [CW-1:0]     q_nxt, q_prev;
  logic [LAW:0]      l_nxt;
  logic [SAW-1:0]    s_free;
  logic              s_free_ok;
  logic [LAW-1:0]    l_free;
  logic              l_free_ok;
  logic [SLOTS-1:0]  act_after;
  logic [REQ_W-1:0]  drop_who;

  tal_ram #(.DEPTH(QUEUE_DEPTH), .WIDTH(REQ_W)) u_queue (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .raddr (q_raddr),
    .rdata (q_rd)
  );

  tal_ram #(.DEPTH(LEASES), .WIDTH(LEW)) u_lease (
    .clk   (clk),
    .we    (l_we),
    .waddr (l_waddr),
    .wdata (l_wdata),
    .raddr (l_raddr),
    .rdata (l_rdata)
  );

  assign l_rd      = lease_ent_t'(l_rdata);
  assign sidx      = SAW'(req_r);
  assign bad       = (kind_r > KIND_ATT) || ({29'd0, req_r} >= 32'(SLOTS));
  assign act       = slot_active[sidx];
  assign sess_open = |slot_active;
  assign head      = (wait_count != '0) && (q_rd == req_r);
  assign contend   = turn_busy || ((wait_count != '0) && !head);
  assign can_q     = (kind_r == KIND_ACQQ) && (wait_count < CW'(QUEUE_DEPTH));
  assign rel_ok    = sess_open && turn_busy && (tag_r == current_tag);
  assign q_nxt     = qidx + CW'(1);
  assign q_prev    = qidx - CW'(1);
  assign q_hit     = (q_rd == req_r);
  assign q_last    = (q_nxt == wait_count);
  assign l_nxt     = {1'b0, lidx} + (LAW + 1)'(1);
  assign l_v       = lease_valid[lidx];
  assign l_sp_hit  = l_v && (l_rd.space == ws_r);
  assign l_own     = (l_rd.owner == req_r);
  assign l_last    = (lidx == LAW'(LEASES - 1));
  assign l_stop    = ((kind_r == KIND_LGET || kind_r == KIND_LQRY) && l_sp_hit) ||
                     ((kind_r == KIND_LDROP) && l_sp_hit && l_own);
  assign drop_who  = (kind_r == KIND_REL) ? turn_owner : req_r;

  always_comb begin
    s_free_ok = 1'b0;
    s_free    = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!slot_active[i]) begin
        s_free_ok = 1'b1;
        s_free    = SAW'(i);
      end
    end
  end

  always_comb begin
    l_free_ok = 1'b0;
    l_free    = '0;
    for (int i = LEASES - 1; i >= 0; i--) begin
      if (!lease_valid[i]) begin
        l_free_ok = 1'b1;
        l_free    = LAW'(i);
      end
    end
  end

  always_comb begin
    act_after       = slot_active;
    act_after[sidx] = slot_keeps[sidx];
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) state_next = S_DEC;
      end
      S_DEC: begin
        state_next = S_DONE;
        if (!bad) begin
          case (kind_r) inside
            KIND_ACQ, KIND_ACQQ: begin
              if (act && contend && can_q && wait_count != '0) state_next = S_QSCAN;
              else if (act && !contend && head && wait_count > CW'(1)) state_next = S_QSHIFT;
            end
            KIND_REL:  if (rel_ok) state_next = S_LSCAN;
            KIND_WDR:  if (wait_count != '0) state_next = S_QSCAN;
            KIND_DET:  if (act) state_next = S_LSCAN;
            KIND_LGET, KIND_LDROP, KIND_LQRY: if (sess_open) state_next = S_LSCAN;
            default: ;
          endcase
        end
      end
      S_QSCAN: begin
        if (q_hit) state_next = (kind_r == KIND_WDR && !q_last) ? S_QSHIFT : S_DONE;
        else if (q_last) state_next = S_DONE;
      end
      S_QSHIFT: begin
        if (q_last) state_next = S_DONE;
      end
      S_LSCAN: begin
        if (l_stop || l_last) state_next = S_DONE;
      end
      S_DONE: begin
        if (res_take) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    slot_active_next = slot_active;
    slot_live_next   = slot_live;
    slot_keeps_next  = slot_keeps;
    turn_busy_next   = turn_busy;
    current_tag_next = current_tag;
    turn_owner_next  = turn_owner;
    wait_count_next  = wait_count;
    lease_valid_next = lease_valid;
    tag_counter_next = tag_counter;
    qidx_next        = qidx;
    lidx_next        = lidx;
    res_next         = res;
    q_we             = 1'b0;
    q_waddr          = '0;
    q_wdata          = req_r;
    q_raddr          = '0;
    l_we             = 1'b0;
    l_waddr          = l_free;
    l_wdata          = {ws_r, req_r};
    l_raddr          = '0;
    unique case (state)
      S_IDLE: ;
      S_DEC: begin
        res_next  = '{status: ST_ERR, tag: '0, pos: '0, slot: '0};
        qidx_next = '0;
        lidx_next = '0;
        if (!bad) begin
          case (kind_r) inside
            KIND_ACQ, KIND_ACQQ: begin
              if (act) begin
                if (contend) begin
                  if (can_q) begin
                    if (wait_count == '0) begin
                      q_we            = 1'b1;
                      wait_count_next = CW'(1);
                      res_next.status = ST_QUEUED;
                      res_next.pos    = POS_W'(1);
                    end
                  end else begin
                    res_next.status = ST_BUSY;
                    res_next.tag    = turn_busy ? current_tag : '0;
                  end
                end else begin
                  if (head) begin
                    if (wait_count == CW'(1)) wait_count_next = '0;
                    else begin
                      qidx_next = CW'(1);
                      q_raddr   = QAW'(1);
                    end
                  end
                  tag_counter_next = tag_counter + TAG_W'(1);
                  current_tag_next = tag_counter + TAG_W'(1);
                  turn_owner_next  = req_r;
                  turn_busy_next   = 1'b1;
                  res_next.status  = ST_OK;
                  res_next.tag     = tag_counter + TAG_W'(1);
                end
              end
            end
            KIND_ATT: begin
              if (!sess_open) begin
                turn_busy_next   = 1'b0;
                current_tag_next = '0;
                turn_owner_next  = '0;
                wait_count_next  = '0;
                lease_valid_next = '0;
              end
              if (s_free_ok) begin
                slot_active_next[s_free] = 1'b1;
                slot_live_next[s_free]   = 1'b1;
                slot_keeps_next[s_free]  = keeps_r;
                tag_counter_next         = tag_counter + TAG_W'(1);
                res_next.status          = ST_OK;
                res_next.slot            = REQ_W'(s_free);
              end
            end
            default: ;
          endcase
        end
      end
      S_QSCAN: begin
        q_raddr   = (q_nxt < CW'(QUEUE_DEPTH)) ? q_nxt[QAW-1:0] : '0;
        qidx_next = q_nxt;
        if (q_hit) begin
          if (kind_r == KIND_WDR) begin
            res_next.status = ST_OK;
            if (q_last) wait_count_next = wait_count - CW'(1);
          end else begin
            res_next.status = ST_QUEUED;
            res_next.pos    = POS_W'(q_nxt);
          end
        end else if (q_last && kind_r != KIND_WDR) begin
          q_we            = 1'b1;
          q_waddr         = wait_count[QAW-1:0];
          wait_count_next = wait_count + CW'(1);
          res_next.status = ST_QUEUED;
          res_next.pos    = POS_W'(wait_count + CW'(1));
        end
      end
      S_QSHIFT: begin
        q_raddr   = (q_nxt < CW'(QUEUE_DEPTH)) ? q_nxt[QAW-1:0] : '0;
        q_we      = 1'b1;
        q_waddr   = q_prev[QAW-1:0];
        q_wdata   = q_rd;
        qidx_next = q_nxt;
        if (q_last) wait_count_next = wait_count - CW'(1);
      end
      S_LSCAN: begin
        l_raddr   = (l_nxt < (LAW + 1)'(LEASES)) ? l_nxt[LAW-1:0] : '0;
        lidx_next = l_nxt[LAW-1:0];
        case (kind_r) inside
          KIND_REL, KIND_DET: begin
            if (l_v && l_rd.owner == drop_who) lease_valid_next[lidx] = 1'b0;
            if (l_last) begin
              res_next.status = ST_OK;
              if (kind_r == KIND_REL || (turn_busy && turn_owner == req_r)) begin
                turn_busy_next   = 1'b0;
                current_tag_next = '0;
                turn_owner_next  = '0;
              end
              if (kind_r == KIND_DET) begin
                slot_live_next[sidx]   = 1'b0;
                slot_active_next[sidx] = slot_keeps[sidx];
                if (act_after == '0) begin
                  turn_busy_next   = 1'b0;
                  current_tag_next = '0;
                  turn_owner_next  = '0;
                  wait_count_next  = '0;
                  lease_valid_next = '0;
                end
              end
            end
          end
          KIND_LGET: begin
            if (l_sp_hit) res_next.status = l_own ? ST_OK : ST_ERR;
            else if (l_last && l_free_ok) begin
              l_we                     = 1'b1;
              lease_valid_next[l_free] = 1'b1;
              res_next.status          = ST_OK;
            end
          end
          KIND_LDROP: begin
            if (l_sp_hit && l_own) begin
              lease_valid_next[lidx] = 1'b0;
              res_next.status        = ST_OK;
            end
          end
          KIND_LQRY: begin
            if (l_sp_hit) begin
              res_next.status = ST_OK;
              res_next.slot   = l_rd.owner;
            end
          end
          default: ;
        endcase
      end
      S_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      slot_active <= '0;
      slot_live   <= '0;
      slot_keeps  <= '0;
      turn_busy   <= 1'b0;
      current_tag <= '0;
      turn_owner  <= '0;
      wait_count  <= '0;
      lease_valid <= '0;
      tag_counter <= '0;
    end else begin
      state       <= state_next;
      slot_active <= slot_active_next;
      slot_live   <= slot_live_next;
      slot_keeps  <= slot_keeps_next;
      turn_busy   <= turn_busy_next;
      current_tag <= current_tag_next;
      turn_owner  <= turn_owner_next;
      wait_count  <= wait_count_next;
      lease_valid <= lease_valid_next;
      tag_counter <= tag_counter_next;
    end
  end

  always_ff @(posedge clk) begin
    qidx <= qidx_next;
    lidx <= lidx_next;
    res  <= res_next;
    if (state == S_IDLE && start) begin
      kind_r  <= kind;
      req_r   <= requester;
      tag_r   <= turn_tag;
      ws_r    <= workspace;
      keeps_r <= keeps_target;
    end
  end

  assign idle      = (state == S_IDLE);
  assign res_valid = (state == S_DONE);

endmodule

// File: test/turn_arbiter_with_leases_chk.sv
// Checker for the turn arbiter with leases: watches both channels, predicts each result.
// Depends on tal_pkg; instantiated by turn_arbiter_with_leases_tb beside the block.
`timescale 1ns / 1ps

module turn_arbiter_with_leases_chk
  import tal_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [KIND_W-1:0] kind,
  input  logic [REQ_W-1:0]  requester,
  input  logic [TAG_W-1:0]  turn_tag,
  input  logic [WS_W-1:0]   workspace,
  input  logic              keeps_target,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [ST_W-1:0]   status,
  input  logic [TAG_W-1:0]  turn_tag_res,
  input  logic [POS_W-1:0]  position,
  input  logic [REQ_W-1:0]  slot,
  output int                fail_count,
  output int                pending
);

  localparam int NS = SLOTS_DEF;
  localparam int NQ = QUEUE_DEF;
  localparam int NL = LEASES_DEF;

  logic             active [NS];
  logic             live   [NS];
  logic             keeps  [NS];
  logic             busy;
  logic [TAG_W-1:0] cur_tag;
  logic [REQ_W-1:0] owner;
  logic [REQ_W-1:0] waitq  [NQ];
  int               wcount;
  logic             lvalid [NL];
  logic [WS_W-1:0]  lspace [NL];
  logic [REQ_W-1:0] lowner [NL];
  logic [TAG_W-1:0] tag_ctr;

  res_t expected_results[$];

  function automatic bit any_active();
    for (int i = 0; i < NS; i++) if (active[i]) return 1;
    return 0;
  endfunction

  function automatic void drop_leases(logic [REQ_W-1:0] who);
    for (int i = 0; i < NL; i++) if (lvalid[i] && lowner[i] == who) lvalid[i] = 0;
  endfunction

  function automatic void pop_wait(int at);
    for (int j = at + 1; j < wcount; j++) waitq[j-1] = waitq[j];
    wcount--;
  endfunction

  function automatic void clear_turn();
    busy = 0;
    cur_tag = '0;
    owner = '0;
  endfunction

  function automatic void close_session();
    clear_turn();
    wcount = 0;
    for (int i = 0; i < NL; i++) lvalid[i] = 0;
  endfunction

  function automatic res_t arbitrate(logic [KIND_W-1:0] k, logic [REQ_W-1:0] r,
                                     logic [TAG_W-1:0] t, logic [WS_W-1:0] w, logic kp);
    res_t res;
    bit head, found, decided;
    int freei;
    res = '0;
    res.status = ST_ERR;
    case (k)
      KIND_ACQ, KIND_ACQQ: begin
        if (active[r]) begin
          head = wcount > 0 && waitq[0] == r;
          if (busy || (wcount > 0 && !head)) begin
            if (k == KIND_ACQQ && wcount < NQ) begin
              found = 0;
              for (int i = 0; i < wcount; i++)
                if (!found && waitq[i] == r) begin
                  found = 1;
                  res.pos = POS_W'(i + 1);
                end
              if (!found) begin
                waitq[wcount] = r;
                wcount++;
                res.pos = POS_W'(wcount);
              end
              res.status = ST_QUEUED;
            end else begin
              res.status = ST_BUSY;
              res.tag = busy ? cur_tag : '0;
            end
          end else begin
            if (head) pop_wait(0);
            tag_ctr++;
            cur_tag = tag_ctr;
            owner = r;
            busy = 1;
            res.status = ST_OK;
            res.tag = cur_tag;
          end
        end
      end
      KIND_REL: begin
        if (any_active() && busy && t == cur_tag) begin
          drop_leases(owner);
          clear_turn();
          res.status = ST_OK;
        end
      end
      KIND_WDR: begin
        for (int i = 0; i < wcount; i++)
          if (waitq[i] == r) begin
            pop_wait(i);
            res.status = ST_OK;
            break;
          end
      end
      KIND_DET: begin
        if (active[r]) begin
          if (busy && owner == r) clear_turn();
          drop_leases(r);
          live[r] = 0;
          if (!keeps[r]) active[r] = 0;
          if (!any_active()) close_session();
          res.status = ST_OK;
        end
      end
      KIND_LGET: begin
        if (any_active()) begin
          freei = -1;
          decided = 0;
          for (int i = 0; i < NL; i++) begin
            if (!decided && lvalid[i] && lspace[i] == w) begin
              res.status = (lowner[i] == r) ? ST_OK : ST_ERR;
              decided = 1;
            end
            if (!decided && !lvalid[i] && freei < 0) freei = i;
          end
          if (!decided && freei >= 0) begin
            lvalid[freei] = 1;
            lspace[freei] = w;
            lowner[freei] = r;
            res.status = ST_OK;
          end
        end
      end
      KIND_LDROP: begin
        if (any_active())
          for (int i = 0; i < NL; i++)
            if (lvalid[i] && lspace[i] == w && lowner[i] == r) begin
              lvalid[i] = 0;
              res.status = ST_OK;
              break;
            end
      end
      KIND_LQRY: begin
        if (any_active())
          for (int i = 0; i < NL; i++)
            if (lvalid[i] && lspace[i] == w) begin
              res.slot = lowner[i];
              res.status = ST_OK;
              break;
            end
      end
      KIND_ATT: begin
        if (!any_active()) close_session();
        for (int i = 0; i < NS; i++)
          if (!active[i]) begin
            active[i] = 1;
            live[i] = 1;
            keeps[i] = kp;
            tag_ctr++;
            res.slot = REQ_W'(i);
            res.status = ST_OK;
            break;
          end
      end
      default: ;
    endcase
    return res;
  endfunction

  assign pending = expected_results.size();

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      for (int i = 0; i < NS; i++) begin
        active[i] = 0;
        live[i] = 0;
        keeps[i] = 0;
      end
      for (int i = 0; i < NQ; i++) waitq[i] = '0;
      for (int i = 0; i < NL; i++) begin
        lspace[i] = '0;
        lowner[i] = '0;
      end
      close_session();
      tag_ctr = '0;
      expected_results.delete();
      fail_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result with nothing expected: status %0d", status);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status);
            fail_count++;
          end
          if (turn_tag_res !== want.tag) begin
            $error("turn_tag_res: expected %0h, actual %0h", want.tag, turn_tag_res);
            fail_count++;
          end
          if (position !== want.pos) begin
            $error("position: expected %0d, actual %0d", want.pos, position);
            fail_count++;
          end
          if (slot !== want.slot) begin
            $error("slot: expected %0d, actual %0d", want.slot, slot);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall)
        expected_results.push_back(arbitrate(kind, requester, turn_tag, workspace,
                                             keeps_target));
    end
  end

endmodule

// File: test/turn_arbiter_with_leases_tb.sv
// Top of the turn arbiter with leases testbench: clock, reset, stimulus and verdict.
// Depends on tal_pkg, turn_arbiter_with_leases and turn_arbiter_with_leases_chk.
`timescale 1ns / 1ps

module turn_arbiter_with_leases_tb;
  import tal_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic              clk = 0;
  logic              rst = 1;
  logic              in_valid = 0;
  logic              in_stall;
  logic [KIND_W-1:0] kind = '0;
  logic [REQ_W-1:0]  requester = '0;
  logic [TAG_W-1:0]  turn_tag = '0;
  logic [WS_W-1:0]   workspace = '0;
  logic              keeps_target = 0;
  logic              out_valid;
  logic              out_stall = 1;
  logic [ST_W-1:0]   status;
  logic [TAG_W-1:0]  turn_tag_res;
  logic [POS_W-1:0]  position;
  logic [REQ_W-1:0]  slot;

  int fail_count;
  int pending;
  int send_idle_pct = 38;
  int recv_idle_pct = 70;
  int phase = 0;
  int hold_off = 0;
  logic held = 0;
  int cycles = 0;
  logic [TAG_W-1:0] last_tag = '0;
  logic [WS_W-1:0]  spaces[4] = '{16'h0000, 16'hffff, 16'h5a5a, 16'h0001};

  always #2 clk = ~clk;

  turn_arbiter_with_leases dut (.*);
  turn_arbiter_with_leases_chk chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("turn_arbiter_with_leases_tb: errors");
      $finish;
    end
  end

  // Receiver: random stalls, and one long hold-off once the last phase starts.
  always @(posedge clk) begin
    if (rst) out_stall <= 1;
    else if (phase == 2 && !held) begin
      held <= 1;
      hold_off <= 300;
      out_stall <= 1;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall <= 1;
    end else out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Track the newest granted tag so releases mostly hit.
  always @(posedge clk)
    if (out_valid && !out_stall && status == ST_OK && turn_tag_res != 0)
      last_tag <= turn_tag_res;

  task automatic send(logic [KIND_W-1:0] k, logic [REQ_W-1:0] r, logic [TAG_W-1:0] t,
                      logic [WS_W-1:0] w, logic kp);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    kind <= k;
    requester <= r;
    turn_tag <= t;
    workspace <= w;
    keeps_target <= kp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic random_item();
    int sel;
    logic [KIND_W-1:0] k;
    logic [TAG_W-1:0] t;
    sel = $urandom_range(99);
    if (sel < 4) k = KIND_W'($urandom_range(15));
    else if (sel < 16) k = KIND_ATT;
    else if (sel < 24) k = KIND_DET;
    else k = KIND_W'($urandom_range(7));
    t = ($urandom_range(3) == 0) ? $urandom() : last_tag;
    send(k, REQ_W'($urandom_range(7)), t,
         ($urandom_range(4) == 0) ? WS_W'($urandom()) : spaces[$urandom_range(3)],
         1'($urandom_range(1)));
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // Directed: no session, attach all, full table, queue, leases, wrong tag, unknown kind.
    send(KIND_ACQ, 0, 0, 0, 0);
    send(KIND_LGET, 0, 0, 16'hffff, 0);
    send(KIND_DET, 7, 0, 0, 0);
    for (int i = 0; i < 8; i++) send(KIND_ATT, 0, 0, 0, 1'(i & 1));
    send(KIND_ATT, 0, 0, 0, 1);
    send(KIND_ACQ, 2, 0, 0, 0);
    send(KIND_ACQ, 3, 0, 0, 0);
    send(KIND_ACQQ, 3, 0, 0, 0);
    send(KIND_ACQQ, 3, 0, 0, 0);
    send(KIND_WDR, 5, 0, 0, 0);
    send(KIND_LGET, 2, 0, 16'hffff, 0);
    send(KIND_LGET, 4, 0, 16'hffff, 0);
    send(KIND_LQRY, 1, 0, 16'hffff, 0);
    send(KIND_LDROP, 2, 0, 16'h0000, 0);
    send(KIND_REL, 0, 32'hffffffff, 0, 0);
    send(KIND_REL, 0, 32'd9, 0, 0);
    send(KIND_W'(15), 7, 0, 0, 0);
    send(KIND_W'(9), 0, 0, 0, 0);
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 38 : (ph == 1) ? 70 : 0;
      recv_idle_pct = (ph == 0) ? 70 : (ph == 1) ? 38 : 0;
      phase = ph;
      repeat (530) random_item();
    end
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) $display("turn_arbiter_with_leases_tb: clean");
    else $display("turn_arbiter_with_leases_tb: errors");
    $finish;
  end

endmodule

// File: files.f
sv/tal_pkg.sv
sv/tal_ram.sv
sv/tal_engine.sv
sv/turn_arbiter_with_leases.sv
test/turn_arbiter_with_leases_chk.sv
test/turn_arbiter_with_leases_tb.sv
